[hw/rtl/pwsfd_pkg.sv]
// Package for the pulse width serial frame decoder.
// Holds payload structs, status codes, sequencer states and fixed constants.
// No dependencies.
package pwsfd_pkg;

  localparam int DurW    = 15;
  localparam int DvdW    = DurW + 1;
  localparam int CharW   = 7;
  localparam int CountW  = 8;
  localparam int PosW    = 4;

  localparam logic [DurW-1:0]   BIT_TIME_RESET  = 15'd833;
  localparam logic [CountW-1:0] MAX_CHARS_RESET = 8'd85;

  // configuration register indexes
  localparam logic CFG_BIT_TIME  = 1'b0;
  localparam logic CFG_MAX_CHARS = 1'b1;

  // deframer positions: 1..7 are data bits
  localparam logic [PosW-1:0] POS_SEARCH = 4'd0;
  localparam logic [PosW-1:0] POS_PARITY = 4'd8;
  localparam logic [PosW-1:0] POS_STOP   = 4'd9;

  localparam logic [CharW-1:0] CHAR_LF = 7'h0A;
  localparam logic [CharW-1:0] CHAR_CR = 7'h0D;

  typedef enum logic [2:0] {
    ST_CHAR      = 3'd0,
    ST_DONE      = 3'd1,
    ST_PARITY    = 3'd2,
    ST_STOP      = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_t;

  typedef struct packed {
    logic            level;
    logic [DurW-1:0] duration;
    logic            first_of_block;
    logic            last_of_block;
  } in_item_t;

  typedef struct packed {
    logic [CharW-1:0] char_out;
    status_t          status;
    logic             last;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_BITS,
    S_END,
    S_FLUSH
  } seq_state_t;

endpackage

[hw/rtl/pwsfd_div.sv]
// Bit-serial restoring divider: one quotient bit per cycle.
// Used to round pulse durations to bit counts. Depends on pwsfd_pkg.
module pwsfd_div
  import pwsfd_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [DvdW-1:0] dividend,
  input  logic [DurW-1:0] divisor,
  output logic            busy,
  output logic            done,
  output logic [DvdW-1:0] quotient
);

  localparam int StepW = $clog2(DvdW);

  logic [DvdW-1:0]  dvd;
  logic [DurW-1:0]  dsr;
  logic [DurW-1:0]  rem;
  logic [StepW-1:0] step;
  logic [DvdW-1:0]  rem_sh;
  logic             fits;

  assign rem_sh = {rem, dvd[DvdW-1]};
  assign fits   = rem_sh >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= StepW'(DvdW - 1);
        dvd  <= dividend;
        dsr  <= divisor;
        rem  <= '0;
      end else if (busy) begin
        dvd      <= {dvd[DvdW-2:0], 1'b0};
        quotient <= {quotient[DvdW-2:0], fits};
        rem      <= fits ? DurW'(rem_sh - {1'b0, dsr}) : rem_sh[DurW-1:0];
        step     <= step - StepW'(1);
        if (step == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_start_busy: assert property (@(posedge clk) disable iff (rst) start |=> busy)
    else $error("divider did not start");
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy) && !busy)
    else $error("done without a running division");
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    busy && !$past(start) |-> rem < dsr)
    else $error("partial remainder not below divisor");
`endif

endmodule

[hw/rtl/pulse_width_serial_frame_decoder.sv]
// Top level of the pulse width serial frame decoder.
// Depends on pwsfd_pkg and pwsfd_div.
//
// Usage:
//   Input channel (in_valid/in_stall/in_data): one captured pulse per transfer,
//   level, duration in ticks, and block start/end marks. in_stall is high while
//   a pulse is being worked on; the block holds one pulse at a time.
//   Output channel (out_valid/out_stall/out_data): zero to two results per
//   pulse; last marks the final result of a pulse.
//   Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data): index 0 bit_time,
//   index 1 max_chars; cfg_ready is always high. Write only while idle.
// Operation: a pulse is accepted, its duration is rounded to a bit count in the
//   bit-serial divider, then its bits (0 to MAX_BITS_PER_PULSE) are applied one
//   per cycle unless a result cannot be buffered, then the block end and the
//   pending result are handled. Pulses seen while halted are accepted and dropped.
// Reset (rst, synchronous): registers go to 833 and 85, decoder state clears,
//   both channels go empty.
// A stalled receiver holds its result in the output register; up to one more
//   result waits inside, and the deframer pauses only when it needs a third.
module pulse_width_serial_frame_decoder
  import pwsfd_pkg::*;
#(
  parameter int MAX_BITS_PER_PULSE = 9
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  in_item_t        in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output out_item_t       out_data,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic            cfg_index,
  input  logic [DurW-1:0] cfg_data
);

  localparam int CntW = $clog2(MAX_BITS_PER_PULSE + 1);

  // configuration
  logic [DurW-1:0]   bit_time;
  logic [CountW-1:0] max_chars;

  // decoder state
  logic [PosW-1:0]   bit_position, bit_position_next;
  logic [CharW-1:0]  char_shift, char_shift_next;
  logic              parity_acc, parity_acc_next;
  logic              prev_was_cr, prev_was_cr_next;
  logic [CountW-1:0] char_count, char_count_next;
  logic              halted, halted_next;

  // sequencer
  seq_state_t        state, state_next;
  logic [CntW-1:0]   bit_cnt, bit_cnt_next;
  logic              item_level, item_level_next;
  logic              item_last, item_last_next;
  logic              pend_valid, pend_valid_next;
  out_item_t         pend, pend_next;
  logic              out_valid_next;
  out_item_t         out_data_next;

  // divider
  logic              div_start;
  logic              div_busy;
  logic              div_done;
  logic [DvdW-1:0]   div_q;
  logic [DurW-1:0]   bt_eff;
  logic [DvdW-1:0]   dividend;

  // one deframer step
  logic              res_v;
  status_t           res_st;
  logic [CharW-1:0]  res_ch;
  logic              out_free;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign out_free  = !out_valid || !out_stall;
  assign bt_eff    = (bit_time == '0) ? DurW'(1) : bit_time;
  assign dividend  = {1'b0, in_data.duration} + {2'b0, bt_eff[DurW-1:1]};

  pwsfd_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (bt_eff),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_time  <= BIT_TIME_RESET;
      max_chars <= MAX_CHARS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_BIT_TIME:  bit_time  <= cfg_data;
        CFG_MAX_CHARS: max_chars <= cfg_data[CountW-1:0];
        default:       ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_position <= POS_SEARCH;
      char_shift   <= '0;
      parity_acc   <= 1'b0;
      prev_was_cr  <= 1'b0;
      char_count   <= '0;
      halted       <= 1'b0;
      pend_valid   <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      bit_position <= bit_position_next;
      char_shift   <= char_shift_next;
      parity_acc   <= parity_acc_next;
      prev_was_cr  <= prev_was_cr_next;
      char_count   <= char_count_next;
      halted       <= halted_next;
      pend_valid   <= pend_valid_next;
      out_valid    <= out_valid_next;
    end
    bit_cnt    <= bit_cnt_next;
    item_level <= item_level_next;
    item_last  <= item_last_next;
    pend       <= pend_next;
    out_data   <= out_data_next;
  end

  // result that the next bit would cause, if any
  always_comb begin
    res_v  = 1'b0;
    res_st = ST_CHAR;
    res_ch = '0;
    if (bit_position == POS_PARITY) begin
      if (parity_acc != item_level) begin
        res_v  = 1'b1;
        res_st = ST_PARITY;
      end else if (char_count < max_chars) begin
        res_v  = 1'b1;
        res_ch = char_shift;
        res_st = (char_shift == CHAR_LF && prev_was_cr) ? ST_DONE : ST_CHAR;
      end
    end else if (bit_position == POS_STOP) begin
      if (item_level) begin
        res_v  = 1'b1;
        res_st = ST_STOP;
      end
    end
  end

  always_comb begin
    state_next        = state;
    bit_position_next = bit_position;
    char_shift_next   = char_shift;
    parity_acc_next   = parity_acc;
    prev_was_cr_next  = prev_was_cr;
    char_count_next   = char_count;
    halted_next       = halted;
    bit_cnt_next      = bit_cnt;
    item_level_next   = item_level;
    item_last_next    = item_last;
    pend_valid_next   = pend_valid;
    pend_next         = pend;
    out_valid_next    = out_valid && out_stall;
    out_data_next     = out_data;
    div_start         = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          item_level_next = in_data.level;
          item_last_next  = in_data.last_of_block;
          if (in_data.first_of_block) begin
            bit_position_next = POS_SEARCH;
            char_shift_next   = '0;
            parity_acc_next   = 1'b0;
            prev_was_cr_next  = 1'b0;
            char_count_next   = '0;
            halted_next       = 1'b0;
          end
          if (in_data.first_of_block || !halted) begin
            div_start  = 1'b1;
            state_next = S_DIV;
          end
        end
      end

      S_DIV: begin
        if (div_done) begin
          if (div_q >= DvdW'(1) && div_q <= DvdW'(MAX_BITS_PER_PULSE)) begin
            bit_cnt_next = div_q[CntW-1:0];
          end else begin
            bit_cnt_next = '0;
          end
          state_next = S_BITS;
        end
      end

      S_BITS: begin
        if (bit_cnt == '0 || halted) begin
          state_next = S_END;
        end else if (!(res_v && pend_valid && !out_free)) begin
          bit_cnt_next = bit_cnt - CntW'(1);
          if (res_v) begin
            if (pend_valid) begin
              out_valid_next = 1'b1;
              out_data_next  = pend;
            end
            pend_valid_next = 1'b1;
            pend_next       = '{char_out: res_ch, status: res_st, last: 1'b0};
          end
          priority if (bit_position == POS_SEARCH) begin
            if (item_level) begin
              bit_position_next = PosW'(1);
              parity_acc_next   = 1'b0;
              char_shift_next   = '0;
            end
          end else if (bit_position == POS_PARITY) begin
            if (res_v && res_st != ST_CHAR) begin
              halted_next = 1'b1;
            end else begin
              bit_position_next = POS_STOP;
              if (res_v) begin
                prev_was_cr_next = (char_shift == CHAR_CR);
                char_count_next  = char_count + CountW'(1);
              end
            end
          end else if (bit_position == POS_STOP) begin
            if (res_v) begin
              halted_next = 1'b1;
            end else begin
              bit_position_next = POS_SEARCH;
            end
          end else begin
            // data bits arrive LSB first; line low is a one
            char_shift_next   = {~item_level, char_shift[CharW-1:1]};
            parity_acc_next   = parity_acc ^ item_level;
            bit_position_next = bit_position + PosW'(1);
          end
        end
      end

      S_END: begin
        if (item_last && !halted) begin
          if (!(pend_valid && !out_free)) begin
            if (pend_valid) begin
              out_valid_next = 1'b1;
              out_data_next  = pend;
            end
            pend_valid_next = 1'b1;
            pend_next       = '{char_out: '0, status: ST_NOT_FOUND, last: 1'b0};
            halted_next     = 1'b1;
            state_next      = S_FLUSH;
          end
        end else begin
          state_next = S_FLUSH;
        end
      end

      S_FLUSH: begin
        if (!pend_valid) begin
          state_next = S_IDLE;
        end else if (out_free) begin
          out_valid_next     = 1'b1;
          out_data_next      = pend;
          out_data_next.last = 1'b1;
          pend_valid_next    = 1'b0;
          state_next         = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

`ifndef NO_ASSERTIONS
  a_idle_no_pend: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !pend_valid)
    else $error("result left pending between pulses");
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    bit_position <= POS_STOP)
    else $error("deframer position out of range");
  a_terminal_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.status == ST_DONE || out_data.status == ST_PARITY ||
                  out_data.status == ST_STOP || out_data.status == ST_NOT_FOUND)
    |-> out_data.last)
    else $error("terminal status not marked last");
  a_div_only_in_div: assert property (@(posedge clk) disable iff (rst)
    div_busy |-> state == S_DIV)
    else $error("divider running outside division state");
`endif

endmodule

[tb/sv/pwsfd_checker.sv]
// Checker for the pulse width serial frame decoder: watches the pulse, result
// and register write channels, predicts the results of each pulse and compares.
// Depends on pwsfd_pkg.
`timescale 1ns / 1ps

module pwsfd_checker
  import pwsfd_pkg::*;
#(
  parameter int MAX_BITS_PER_PULSE = 9
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic            in_stall,
  input  in_item_t        in_data,
  input  logic            out_valid,
  input  logic            out_stall,
  input  out_item_t       out_data,
  input  logic            cfg_valid,
  input  logic            cfg_ready,
  input  logic            cfg_index,
  input  logic [DurW-1:0] cfg_data,
  output int              pending,
  output int              fails
);

  logic [DurW-1:0]   bit_time_q;
  logic [CountW-1:0] max_chars_q;

  // decoder mirror
  logic [PosW-1:0]   bit_pos;
  logic [CharW-1:0]  shift_q;
  logic              par_q;
  logic              prev_cr;
  logic [CountW-1:0] stored;
  logic              halted;

  out_item_t expected_q[$];

  task automatic note_mismatch(input string msg);
    fails++;
    $display("pwsfd_checker: mismatch at %0t: %s", $time, msg);
  endtask

  task automatic clear_frame();
    bit_pos = POS_SEARCH;
    shift_q = '0;
    par_q = 1'b0;
    prev_cr = 1'b0;
    stored = '0;
    halted = 1'b0;
  endtask

  function automatic void queue_result(input logic [CharW-1:0] ch, input status_t st);
    out_item_t r;
    r.char_out = ch;
    r.status = st;
    r.last = 1'b0;
    expected_q.push_back(r);
  endfunction

  // Runs one pulse through the deframer and queues the results it causes.
  task automatic deframe_pulse(input in_item_t p);
    int unsigned bt;
    int unsigned nbits;
    int          first_idx;
    out_item_t   tail;
    first_idx = expected_q.size();
    if (p.first_of_block) clear_frame();
    if (halted) return;
    bt = (bit_time_q == '0) ? 1 : bit_time_q;
    nbits = (p.duration + bt / 2) / bt;
    // out-of-range counts apply none of the pulse's bits, no wrap
    if (nbits < 1 || nbits > MAX_BITS_PER_PULSE) nbits = 0;
    while (nbits > 0 && !halted) begin
      if (bit_pos == POS_SEARCH) begin
        if (p.level) begin
          bit_pos = 4'd1;
          par_q = 1'b0;
          shift_q = '0;
        end
      end else if (bit_pos == POS_PARITY) begin
        if (par_q != p.level) begin
          queue_result('0, ST_PARITY);
          halted = 1'b1;
          break;
        end
        // full buffer: char dropped silently, prev_cr untouched
        if (stored < max_chars_q) begin
          if (shift_q == CHAR_LF && prev_cr) begin
            queue_result(shift_q, ST_DONE);
            halted = 1'b1;
            break;
          end
          queue_result(shift_q, ST_CHAR);
          prev_cr = (shift_q == CHAR_CR);
          stored++;
        end
        bit_pos = POS_STOP;
      end else if (bit_pos == POS_STOP) begin
        if (p.level) begin
          queue_result('0, ST_STOP);
          halted = 1'b1;
          break;
        end
        bit_pos = POS_SEARCH;
      end else begin
        // inverted data: low line level is a one
        if (!p.level) shift_q[bit_pos - 4'd1] = 1'b1;
        else par_q = ~par_q;
        bit_pos++;
      end
      nbits--;
    end
    if (p.last_of_block && !halted) begin
      queue_result('0, ST_NOT_FOUND);
      halted = 1'b1;
    end
    if (expected_q.size() > first_idx) begin
      tail = expected_q.pop_back();
      tail.last = 1'b1;
      expected_q.push_back(tail);
    end
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (expected_q.size() == 0) begin
      note_mismatch($sformatf("unexpected result char %0h status %0d last %0b",
                              got.char_out, got.status, got.last));
      return;
    end
    want = expected_q.pop_front();
    if (got.char_out !== want.char_out) begin
      note_mismatch($sformatf("char_out %0h, want %0h", got.char_out, want.char_out));
    end
    if (got.status !== want.status) begin
      note_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
    end
    if (got.last !== want.last) begin
      note_mismatch($sformatf("last %0b, want %0b", got.last, want.last));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      bit_time_q = BIT_TIME_RESET;
      max_chars_q = MAX_CHARS_RESET;
      clear_frame();
      expected_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_BIT_TIME) bit_time_q = cfg_data;
        else max_chars_q = cfg_data[CountW-1:0];
      end
      // a result can't come from a pulse accepted at the same edge
      if (out_valid && !out_stall) check_result(out_data);
      if (in_valid && !in_stall) deframe_pulse(in_data);
    end
    pending <= expected_q.size();
  end

endmodule

[tb/sv/tb_top.sv]
// Top of the pulse width serial frame decoder testbench: clock, reset, pulse
// stimulus, register writes, result stalls and the verdict.
// Depends on pwsfd_pkg, pwsfd_checker and the decoder RTL.
`timescale 1ns / 1ps

module tb_top;
  import pwsfd_pkg::*;

  localparam int MaxBits      = 9;
  localparam int StallLimit   = 4000;
  localparam int SettleCycles = 40;
  localparam int HoldCycles   = 400;
  localparam int MaxDur       = 32767;

  localparam int FLAW_NONE   = 0;
  localparam int FLAW_PARITY = 1;
  localparam int FLAW_STOP   = 2;

  logic            clk;
  logic            rst = 1'b1;
  logic            in_valid = 1'b0;
  logic            in_stall;
  in_item_t        in_data = '0;
  logic            out_valid;
  logic            out_stall = 1'b0;
  out_item_t       out_data;
  logic            cfg_valid = 1'b0;
  logic            cfg_ready;
  logic            cfg_index = CFG_BIT_TIME;
  logic [DurW-1:0] cfg_data = '0;

  int pending;
  int fails;

  int cur_bt = 833;
  int max_chunk = MaxBits;
  int items_sent = 0;
  int tx_idle_pct = 28;
  int rx_idle_pct = 48;
  bit hold_flip = 1'b0;
  bit hold_seen = 1'b0;
  int hold_left = 0;
  int quiet = 0;

  bit line_bits[$];

  pulse_width_serial_frame_decoder #(
    .MAX_BITS_PER_PULSE(MaxBits)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  pwsfd_checker #(
    .MAX_BITS_PER_PULSE(MaxBits)
  ) i_checker (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .pending  (pending),
    .fails    (fails)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // result side: random stalls, or a long hold-off when asked
  always @(posedge clk) begin
    if (hold_flip != hold_seen) begin
      hold_seen <= hold_flip;
      hold_left <= HoldCycles;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else if (quiet == StallLimit) begin
      $display("tb_top NOT OK");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  function automatic in_item_t raw_pulse(input bit lvl, input int dur, input bit first,
                                         input bit last);
    in_item_t p;
    p.level = lvl;
    p.duration = DurW'(dur);
    p.first_of_block = first;
    p.last_of_block = last;
    return p;
  endfunction

  // duration that rounds to n bit times, jittered across the whole rounding window
  function automatic logic [DurW-1:0] pulse_len(input int n);
    int d;
    d = n * cur_bt + int'($urandom_range(cur_bt - 1)) - cur_bt / 2;
    if (d > MaxDur) d = MaxDur;
    if (d < 0) d = 0;
    return DurW'(d);
  endfunction

  function automatic logic [CharW-1:0] pick_char();
    int r;
    r = $urandom_range(99);
    if (r < 8) return CHAR_CR;
    if (r < 16) return CHAR_LF;
    return CharW'($urandom_range(127));
  endfunction

  task automatic drive_pulse(input in_item_t p);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= p;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_cfg(input int bt, input int mc);
    drain_results();
    // a pulse with no result may still be in flight
    repeat (SettleCycles) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_BIT_TIME;
    cfg_data <= DurW'(bt);
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= CFG_MAX_CHARS;
    cfg_data <= DurW'(mc);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cur_bt = (bt == 0) ? 1 : bt;
    max_chunk = (MaxDur + cur_bt / 2) / cur_bt;
    if (max_chunk > MaxBits) max_chunk = MaxBits;
  endtask

  // one inverted 7E1 frame onto the line
  task automatic add_char(input logic [CharW-1:0] ch, input int flaw);
    bit par;
    int i;
    par = 1'b0;
    line_bits.push_back(1'b1);
    for (i = 0; i < CharW; i++) begin
      line_bits.push_back(~ch[i]);
      par ^= ~ch[i];
    end
    line_bits.push_back((flaw == FLAW_PARITY) ? ~par : par);
    line_bits.push_back(flaw == FLAW_STOP);
  endtask

  // run-length encodes the line into pulses and sends them as one block
  task automatic send_line();
    in_item_t p;
    int       i;
    int       run;
    int       n;
    bit       lv;
    bit       opening;
    i = 0;
    opening = 1'b1;
    while (i < line_bits.size()) begin
      lv = line_bits[i];
      run = 0;
      while (i < line_bits.size() && line_bits[i] == lv) begin
        run++;
        i++;
      end
      while (run > 0) begin
        n = $urandom_range((run < max_chunk) ? run : max_chunk, 1);
        run -= n;
        p.level = lv;
        p.duration = pulse_len(n);
        p.first_of_block = opening;
        p.last_of_block = (i == line_bits.size() && run == 0);
        opening = 1'b0;
        drive_pulse(p);
      end
    end
    line_bits.delete();
  endtask

  task automatic send_response(input int nchars, input bit with_end, input int flaw_at,
                               input int flaw);
    int k;
    for (k = 0; k < nchars; k++) begin
      repeat ($urandom_range(2)) line_bits.push_back(1'b0);
      add_char(pick_char(), (k == flaw_at) ? flaw : FLAW_NONE);
    end
    if (with_end) begin
      add_char(CHAR_CR, FLAW_NONE);
      add_char(CHAR_LF, FLAW_NONE);
    end
    repeat ($urandom_range(3)) line_bits.push_back(1'b0);
    send_line();
  endtask

  task automatic send_noise(input int count);
    int k;
    int dur;
    for (k = 0; k < count; k++) begin
      if ($urandom_range(1)) dur = $urandom_range(MaxDur);
      else dur = int'(pulse_len($urandom_range(12)));
      drive_pulse(raw_pulse(1'($urandom_range(1)), dur, $urandom_range(9) == 0,
                            $urandom_range(9) == 0));
    end
  endtask

  task automatic run_random(input int count);
    int stop_at;
    int pick;
    int n;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 60) begin
        send_response($urandom_range(6), 1'b1, -1, FLAW_NONE);
      end else if (pick < 75) begin
        send_response($urandom_range(6, 1), 1'b0, -1, FLAW_NONE);
      end else if (pick < 88) begin
        n = $urandom_range(5, 1);
        send_response(n, 1'($urandom_range(1)), $urandom_range(n - 1),
                      $urandom_range(1) ? FLAW_PARITY : FLAW_STOP);
      end else begin
        send_noise($urandom_range(6, 1));
      end
    end
  endtask

  initial begin
    int               k;
    logic [CharW-1:0] ch;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // bit counts: zero, far over range, just over range
    drive_pulse(raw_pulse(1'b1, 0, 1'b1, 1'b0));
    drive_pulse(raw_pulse(1'b1, MaxDur, 1'b0, 1'b0));
    drive_pulse(raw_pulse(1'b0, MaxDur, 1'b0, 1'b0));
    drive_pulse(raw_pulse(1'b1, cur_bt * (MaxBits + 1), 1'b0, 1'b0));
    // LF as first char is plain data; the second one closes the response
    add_char(CHAR_LF, FLAW_NONE);
    add_char(CHAR_CR, FLAW_NONE);
    add_char(CHAR_LF, FLAW_NONE);
    send_line();
    // halted: block end yields nothing
    drive_pulse(raw_pulse(1'b0, cur_bt, 1'b0, 1'b1));
    add_char(7'h7F, FLAW_PARITY);
    send_line();
    add_char(7'h00, FLAW_STOP);
    send_line();
    add_char(7'h7F, FLAW_NONE);
    send_line();

    // overflow the character store; mostly compact frames to keep it short
    for (k = 0; k < 90; k++) begin
      if ($urandom_range(9) < 8) ch = $urandom_range(1) ? 7'h7F : 7'h00;
      else ch = CharW'($urandom_range(127));
      if (ch == CHAR_LF) ch = 7'h0B;
      add_char(ch, FLAW_NONE);
    end
    add_char(CHAR_CR, FLAW_NONE);
    add_char(CHAR_LF, FLAW_NONE);
    send_line();
    run_random(85);

    write_cfg(2, 255);
    run_random(90);

    tx_idle_pct = 48;
    rx_idle_pct <= 28;
    write_cfg(MaxDur, 85);
    run_random(85);
    write_cfg(0, 170);
    run_random(90);

    tx_idle_pct = 0;
    rx_idle_pct <= 0;
    write_cfg($urandom_range(3000, 3), $urandom_range(254, 86));
    run_random(25);
    // long receiver hold-off while pulses keep coming
    hold_flip <= ~hold_flip;
    run_random(75);
    write_cfg(40, 128);
    run_random(70);

    drain_results();
    repeat (SettleCycles) @(posedge clk);
    if (fails == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
